[src/assert_macros.svh]
// Assertion macros shared by the servo bank checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define SB_ASSERT_IMPL(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("servo bank check failed");

// Next-cycle implication, disabled while reset is low
`define SB_ASSERT_NEXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("servo bank check failed");

`endif

[src/sb_pkg.sv]
// Servo bank package: command codes, control structs and calibration tables
package sb_pkg;

  localparam int NUM_SERVOS_DEF = 12;
  localparam logic [15:0] DUR_RESET = 16'd3000;

  typedef enum logic [1:0] {
    CMD_SET_SERVO = 2'd0,
    CMD_SET_LEG   = 2'd1,
    CMD_TICK      = 2'd2,
    CMD_NONE      = 2'd3
  } sb_op_t;

  // controller to datapath
  typedef struct packed {
    logic       latch;
    logic       set_wr;
    logic       load;
    logic       div_step;
    logic       mul;
    logic       wb;
    logic       pmul;
    logic [3:0] idx;
    logic [1:0] joint;
  } sb_cmd_t;

  // datapath to controller
  typedef struct packed {
    sb_op_t op;
    logic   moving;
    logic   big;
  } sb_sta_t;

  // PWM minimum count per servo
  function automatic logic [7:0] pwm_min(input logic [3:0] s);
    logic [7:0] v;
    case (s)
      4'd0:  v = 8'd114;
      4'd1:  v = 8'd112;
      4'd2:  v = 8'd123;
      4'd3:  v = 8'd117;
      4'd4:  v = 8'd114;
      4'd5:  v = 8'd130;
      4'd6:  v = 8'd118;
      4'd7:  v = 8'd112;
      4'd8:  v = 8'd123;
      4'd9:  v = 8'd117;
      4'd10: v = 8'd118;
      4'd11: v = 8'd126;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // counts per degree, Q2.12
  function automatic logic [13:0] pwm_factor(input logic [3:0] s);
    logic [13:0] v;
    case (s)
      4'd0:  v = 14'd9703;
      4'd1:  v = 14'd9712;
      4'd2:  v = 14'd9409;
      4'd3:  v = 14'd9486;
      4'd4:  v = 14'd9622;
      4'd5:  v = 14'd9081;
      4'd6:  v = 14'd9363;
      4'd7:  v = 14'd9732;
      4'd8:  v = 14'd9409;
      4'd9:  v = 14'd9527;
      4'd10: v = 14'd9527;
      4'd11: v = 14'd9286;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

  // rest pose, Q8.8 degrees
  function automatic logic [15:0] rest_pose(input logic [3:0] s);
    logic [15:0] v;
    case (s)
      4'd0, 4'd3, 4'd6, 4'd9: v = 16'd23040;
      4'd1, 4'd7:             v = 16'd40960;
      4'd4, 4'd10:            v = 16'd7680;
      4'd5, 4'd11:            v = 16'd46080;
      default:                v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

[src/sb_if.sv]
// Channel interfaces: command input and per-servo result output
interface sb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [3:0]  servo_sel;
  logic [1:0]  leg;
  logic [15:0] angle_a;
  logic [15:0] angle_b;
  logic [15:0] angle_c;
  logic [15:0] tick_ms;

  modport source (output valid, command, servo_sel, leg, angle_a, angle_b,
                  angle_c, tick_ms, input ready);
  modport sink (input valid, command, servo_sel, leg, angle_a, angle_b,
                angle_c, tick_ms, output ready);
endinterface

interface sb_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  servo_index;
  logic [11:0] pwm_count;
  logic        pwm_written;
  logic        all_reached;
  logic        last_item;

  modport source (output valid, servo_index, pwm_count, pwm_written, all_reached,
                  last_item, input ready);
  modport sink (input valid, servo_index, pwm_count, pwm_written, all_reached,
                last_item, output ready);
endinterface

[src/sb_ctrl.sv]
// Servo bank controller: sequences set writes, the ramp pass and the result pass
module sb_ctrl #(
  parameter int NUM_SERVOS = sb_pkg::NUM_SERVOS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  sb_pkg::sb_sta_t sta,
  output sb_pkg::sb_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SET  = 8'b0000_0010,
    S_LOAD = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_WB   = 8'b0010_0000,
    S_PMUL = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  localparam logic [3:0] LAST_IDX = 4'(NUM_SERVOS - 1);

  state_t     state_r, state_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       acc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign acc       = in_valid && in_ready;

  // command word to the datapath
  always_comb begin
    cmd          = '0;
    cmd.latch    = acc;
    cmd.set_wr   = (state_r == S_SET);
    cmd.load     = (state_r == S_LOAD);
    cmd.div_step = (state_r == S_DIV);
    cmd.mul      = (state_r == S_MUL);
    cmd.wb       = (state_r == S_WB);
    cmd.pmul     = (state_r == S_PMUL);
    cmd.idx      = idx_r;
    cmd.joint    = cnt_r[1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        cnt_nxt = '0;
        if (acc) state_nxt = S_SET;
      end
      S_SET: begin
        // the latched opcode is visible from this cycle on
        unique case (sta.op)
          sb_pkg::CMD_SET_SERVO: state_nxt = S_IDLE;
          sb_pkg::CMD_SET_LEG: begin
            cnt_nxt = cnt_r + 4'd1;
            if (cnt_r[1:0] == 2'd2) state_nxt = S_IDLE;
          end
          sb_pkg::CMD_TICK: state_nxt = S_LOAD;
          default:          state_nxt = S_IDLE;
        endcase
      end
      S_LOAD: begin
        cnt_nxt = '0;
        if (!sta.moving) begin
          if (idx_r == LAST_IDX) begin
            idx_nxt   = '0;
            state_nxt = S_PMUL;
          end else begin
            idx_nxt   = idx_r + 4'd1;
          end
        end else if (sta.big) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_WB;
      S_WB: begin
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_PMUL;
        end else begin
          idx_nxt   = idx_r + 4'd1;
          state_nxt = S_LOAD;
        end
      end
      S_PMUL: state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          if (idx_r == LAST_IDX) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 4'd1;
            state_nxt = S_PMUL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[src/sb_dp.sv]
// Servo bank datapath: angle stores, serial divider, ramp and PWM multipliers
module sb_dp #(
  parameter int NUM_SERVOS = sb_pkg::NUM_SERVOS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sb_pkg::sb_cmd_t cmd,
  output sb_pkg::sb_sta_t sta,
  input  logic [1:0]      in_command,
  input  logic [3:0]      in_servo_sel,
  input  logic [1:0]      in_leg,
  input  logic [15:0]     in_angle_a,
  input  logic [15:0]     in_angle_b,
  input  logic [15:0]     in_angle_c,
  input  logic [15:0]     in_tick_ms,
  input  logic            cfg_wr_en,
  input  logic [15:0]     cfg_wr_data,
  output logic [3:0]      out_servo_index,
  output logic [11:0]     out_pwm_count,
  output logic            out_pwm_written,
  output logic            out_all_reached,
  output logic            out_last_item
);

  localparam int IW = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam logic [4:0] NS = 5'(NUM_SERVOS);

  // state stores
  logic [15:0] cur_arr [NUM_SERVOS];
  logic [15:0] tgt_arr [NUM_SERVOS];
  logic [15:0] el_arr  [NUM_SERVOS];
  logic [NUM_SERVOS-1:0] moved_r;
  logic        all_r;
  logic [15:0] dur_r;

  // latched item
  sb_pkg::sb_op_t op_r;
  logic [3:0]  chan_r;
  logic [1:0]  leg_r;
  logic [15:0] a_r, b_r, c_r, dt_r;

  // working registers
  logic [15:0] cur_r, tgt_r, e_r, q_r;
  logic [16:0] rem_r;
  logic        big_r;
  logic signed [34:0] prod_r;
  logic [29:0] pm_r;

  logic [IW-1:0] rd;
  logic [15:0] el_rd, e_sat;
  logic [16:0] e_sum, rem_sh, t_val;
  logic [3:0]  wa4;
  logic        wa_ok;
  logic [15:0] wa_ang;
  logic signed [16:0] diff;
  logic signed [34:0] rnd;
  logic [15:0] new_ang;
  logic [10:0] pwm_sum;

  assign rd = cmd.idx[IW-1:0];

  // elapsed update with saturation
  assign el_rd = el_arr[rd];
  assign e_sum = {1'b0, el_rd} + {1'b0, dt_r};
  assign e_sat = e_sum[16] ? 16'hFFFF : e_sum[15:0];

  assign sta.op     = op_r;
  assign sta.moving = (el_rd < dur_r);
  assign sta.big    = (e_sat >= dur_r);

  // target write address and angle
  always_comb begin
    if (op_r == sb_pkg::CMD_SET_SERVO) begin
      wa4    = chan_r;
      wa_ang = a_r;
    end else begin
      wa4 = {1'b0, leg_r, 1'b0} + {2'b00, leg_r} + {2'b00, cmd.joint};
      case (cmd.joint)
        2'd0:    wa_ang = a_r;
        2'd1:    wa_ang = b_r;
        default: wa_ang = c_r;
      endcase
    end
    wa_ok = ({1'b0, wa4} < NS) &&
            (op_r == sb_pkg::CMD_SET_SERVO || op_r == sb_pkg::CMD_SET_LEG);
  end

  // restoring division, one quotient bit a step
  assign rem_sh = {rem_r[15:0], 1'b0};

  // ramp: cur + round((tgt - cur) * t / 65536)
  assign t_val   = big_r ? 17'h10000 : {1'b0, q_r};
  assign diff    = $signed({1'b0, tgt_r}) - $signed({1'b0, cur_r});
  assign rnd     = prod_r + 35'sd32768;
  assign new_ang = cur_r + rnd[31:16];

  // PWM result
  assign pwm_sum         = {3'b000, sb_pkg::pwm_min(cmd.idx)} + {1'b0, pm_r[29:20]};
  assign out_servo_index = cmd.idx;
  assign out_pwm_count   = {1'b0, pwm_sum};
  assign out_pwm_written = moved_r[rd];
  assign out_all_reached = all_r;
  assign out_last_item   = (cmd.idx == 4'(NUM_SERVOS - 1));

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r <= sb_pkg::DUR_RESET;
    end else if (cfg_wr_en) begin
      dur_r <= cfg_wr_data;
    end
  end

  // item latch and working registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= sb_pkg::sb_op_t'(in_command);
      chan_r <= in_servo_sel;
      leg_r  <= in_leg;
      a_r    <= in_angle_a;
      b_r    <= in_angle_b;
      c_r    <= in_angle_c;
      dt_r   <= in_tick_ms;
    end
    if (cmd.load) begin
      cur_r <= cur_arr[rd];
      tgt_r <= tgt_arr[rd];
      e_r   <= e_sat;
      big_r <= sta.big;
      rem_r <= {1'b0, e_sat};
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dur_r}) begin
        rem_r <= rem_sh - {1'b0, dur_r};
        q_r   <= {q_r[14:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[14:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      prod_r <= diff * $signed({1'b0, t_val});
    end
    if (cmd.pmul) begin
      pm_r <= cur_arr[rd] * sb_pkg::pwm_factor(cmd.idx);
    end
  end

  // servo stores and tick flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
        cur_arr[i] <= sb_pkg::rest_pose(4'(i));
        tgt_arr[i] <= sb_pkg::rest_pose(4'(i));
        el_arr[i]  <= '0;
      end
      moved_r <= '0;
      all_r   <= 1'b1;
    end else begin
      if (cmd.latch) all_r <= 1'b1;
      if (cmd.set_wr && wa_ok) begin
        tgt_arr[wa4[IW-1:0]] <= wa_ang;
        el_arr[wa4[IW-1:0]]  <= '0;
      end
      if (cmd.load) moved_r[rd] <= sta.moving;
      if (cmd.wb) begin
        cur_arr[rd] <= new_ang;
        el_arr[rd]  <= e_r;
        if (e_r < dur_r) all_r <= 1'b0;
      end
    end
  end

endmodule

[src/servo_bank_ramp_to_pwm.sv]
// Servo bank ramp to PWM: top level joining controller and datapath
//
//   channel | dir | handshake      | moves per transfer
//   in_ch   | in  | valid / ready  | one command (set servo, set leg, tick)
//   out_ch  | out | valid / ready  | one servo result, NUM_SERVOS per tick
//   cfg     | in  | write enable   | move duration in ms
//
// Set-servo writes one target, set-leg the leg's three joints in turn. A tick
// passes the set state, then visits each servo: a still servo is only loaded, a
// moving one runs load, the 16-step serial divider, multiply and write-back (no
// divider when the ramp completes on this tick); then a PWM multiply per result.
// Reset is synchronous; stores return to the rest pose at once.
// A stall on out_ch holds the result; no new command is taken until the
// last result of a tick has been transferred.
module servo_bank_ramp_to_pwm #(
  parameter int NUM_SERVOS = sb_pkg::NUM_SERVOS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sb_in_if.sink       in_ch,
  sb_out_if.source    out_ch,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  sb_pkg::sb_cmd_t cmd;
  sb_pkg::sb_sta_t sta;

  sb_ctrl #(.NUM_SERVOS(NUM_SERVOS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sta       (sta),
    .cmd       (cmd)
  );

  sb_dp #(.NUM_SERVOS(NUM_SERVOS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sta              (sta),
    .in_command       (in_ch.command),
    .in_servo_sel     (in_ch.servo_sel),
    .in_leg           (in_ch.leg),
    .in_angle_a       (in_ch.angle_a),
    .in_angle_b       (in_ch.angle_b),
    .in_angle_c       (in_ch.angle_c),
    .in_tick_ms       (in_ch.tick_ms),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_servo_index  (out_ch.servo_index),
    .out_pwm_count    (out_ch.pwm_count),
    .out_pwm_written  (out_ch.pwm_written),
    .out_all_reached  (out_ch.all_reached),
    .out_last_item    (out_ch.last_item)
  );

endmodule

[src/sb_checker.sv]
// Port-level checker for the servo bank, bound to the top level
`include "assert_macros.svh"

module sb_checker #(
  parameter int NUM_SERVOS = sb_pkg::NUM_SERVOS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_servo_index,
  input logic [11:0] out_pwm_count,
  input logic        out_last_item
);

  // a stalled result holds
  `SB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_servo_index) && $stable(out_pwm_count))
  // no command is taken while results are pending
  `SB_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  // the final result belongs to the last servo
  `SB_ASSERT_IMPL(a_last_idx, clk, rst_n, out_valid && out_last_item, out_servo_index == 4'(NUM_SERVOS - 1))
  // after the final transfer the block returns to taking commands
  `SB_ASSERT_NEXT(a_last_done, clk, rst_n, out_valid && out_ready && out_last_item, !out_valid && in_ready)
  // after a non-final transfer, valid drops for the next PWM multiply
  `SB_ASSERT_NEXT(a_gap, clk, rst_n, out_valid && out_ready && !out_last_item, !out_valid)

endmodule

bind servo_bank_ramp_to_pwm sb_checker #(.NUM_SERVOS(NUM_SERVOS)) u_sb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_servo_index (out_ch.servo_index),
  .out_pwm_count   (out_ch.pwm_count),
  .out_last_item   (out_ch.last_item)
);
